/* rtl/intel_hex_window_loader_macros.svh */
// Assertion macros shared by the loader RTL files.
`ifndef INTEL_HEX_WINDOW_LOADER_MACROS_SVH
`define INTEL_HEX_WINDOW_LOADER_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define IHWL_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define IHWL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/ihwl_pkg.sv */
// Types, constants and helper functions of the hex window loader.
package ihwl_pkg;

  // Line buffer limit and the position counter sized from it
  localparam int LINE_CHARS = 500;
  localparam int POS_W      = $clog2(LINE_CHARS);
  localparam int CMP_W      = (POS_W > 8) ? POS_W : 8;

  localparam logic [POS_W-1:0] POS_LIMIT      = POS_W'(LINE_CHARS - 1);
  localparam logic [POS_W-1:0] POS_START      = POS_W'(0);
  localparam logic [POS_W-1:0] POS_LEN_END    = POS_W'(2);
  localparam logic [POS_W-1:0] POS_OFS_END    = POS_W'(6);
  localparam logic [POS_W-1:0] POS_KIND       = POS_W'(8);
  localparam logic [POS_W-1:0] POS_BODY_START = POS_W'(9);
  localparam logic [POS_W-1:0] POS_SEG_END    = POS_W'(12);
  localparam logic [POS_W-1:0] POS_DATA_BASE  = POS_W'(10);

  // Character codes
  localparam logic [7:0] CHAR_COLON     = 8'h3A;
  localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_NINE      = 8'h39;
  localparam logic [7:0] CHAR_ONE       = 8'h31;
  localparam logic [7:0] CHAR_FOUR      = 8'h34;
  localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
  localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
  localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F   = 8'h46;

  // Configuration register indexes
  localparam int         CFG_IDX_W       = 8;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH = CFG_IDX_W'(1);

  // One result transaction
  typedef struct packed {
    logic [31:0] offset;
    logic [7:0]  data;
    logic        eof;
  } result_t;

  // Decode one hex digit; anything else reads as zero
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      v = c - CHAR_ZERO;
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
      v = c - CHAR_LOWER_A + 8'd10;
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
      v = c - CHAR_UPPER_A + 8'd10;
    end
    return v[3:0];
  endfunction

endpackage

/* rtl/ihwl_out_buf.sv */
// Two-entry result buffer between the parser and the output channel.
`include "intel_hex_window_loader_macros.svh"

module ihwl_out_buf
  import ihwl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  result_t     mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign out_data  = mem[rd_ptr];

  // Store results as they arrive
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  `IHWL_ASSERT(a_no_overfill, clk, rst, !(full && push), "push into a full result buffer")
  `IHWL_ASSERT(a_count_range, clk, rst, count != 2'd3, "result buffer count out of range")
  `IHWL_ASSERT(a_ptr_gap, clk, rst, (count == 2'd1) == (wr_ptr != rd_ptr), "pointers disagree with count")

endmodule

/* rtl/intel_hex_window_loader.sv */
// Top level of the hex window loader: character parser and result buffer.
//
// Takes one character per cycle and turns hex records into byte writes
// relative to window_low, plus one end-of-file transaction. Every character
// is parsed in the cycle it is accepted; a resulting transaction enters a
// two-entry output buffer, which registers it before it reaches the output. The
// input stalls only while that buffer holds two results that the output side
// has not taken, so with the output free the sustained rate is one character
// per clock. Configuration writes are always taken (cfg_ready is tied high)
// and must only occur while the block is idle. No clearing pass is needed
// after reset.
`include "intel_hex_window_loader_macros.svh"

module intel_hex_window_loader
  import ihwl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           char_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [31:0]          write_offset,
  output logic [7:0]           write_data,
  output logic                 end_of_file,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  logic [31:0]      window_low;
  logic [31:0]      window_high;

  logic [POS_W-1:0] line_position, line_position_next;
  logic             line_ignored, line_ignored_next;
  logic             escape_pending, escape_pending_next;
  logic [7:0]       record_kind_char, record_kind_char_next;
  logic [7:0]       record_length, record_length_next;
  logic [15:0]      record_offset, record_offset_next;
  logic [15:0]      segment_base, segment_base_next;
  logic [15:0]      pending_segment, pending_segment_next;
  logic [3:0]       high_nibble, high_nibble_next;
  logic             loading_finished, loading_finished_next;
  logic [32:0]      data_addr, data_addr_next;

  logic             accept;
  logic             push;
  result_t          push_data;
  result_t          out_data;
  logic             buf_full;
  logic [3:0]       digit;
  logic [POS_W-1:0] byte_index;
  logic             in_window;

  assign cfg_ready = 1'b1;
  assign in_stall  = buf_full;
  assign accept    = in_valid && !in_stall;

  assign digit      = hex_value(char_in);
  assign byte_index = (line_position - POS_DATA_BASE) >> 1;
  assign in_window  = (data_addr >= {1'b0, window_low}) && (data_addr <= {1'b0, window_high});

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_low  <= 32'h0000_0000;
      window_high <= 32'hFFFF_FFFF;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WINDOW_LOW:  window_low  <= cfg_data;
        REG_WINDOW_HIGH: window_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Parse one character
  always_comb begin
    line_position_next    = line_position;
    line_ignored_next     = line_ignored;
    escape_pending_next   = escape_pending;
    record_kind_char_next = record_kind_char;
    record_length_next    = record_length;
    record_offset_next    = record_offset;
    segment_base_next     = segment_base;
    pending_segment_next  = pending_segment;
    high_nibble_next      = high_nibble;
    loading_finished_next = loading_finished;
    data_addr_next        = data_addr;
    push                  = 1'b0;
    push_data             = '0;

    if (accept && !loading_finished) begin
      priority if (escape_pending) begin
        escape_pending_next = 1'b0;
      end else if (char_in == CHAR_BACKSLASH) begin
        escape_pending_next = 1'b1;
      end else if (char_in == CHAR_NEWLINE) begin
        // Close the line and act on its record kind
        if (line_position != POS_START && !line_ignored) begin
          if (record_kind_char == CHAR_FOUR) begin
            segment_base_next = pending_segment;
          end else if (record_kind_char == CHAR_ONE) begin
            loading_finished_next = 1'b1;
            push                  = 1'b1;
            push_data.eof         = 1'b1;
          end
        end
        line_position_next    = POS_START;
        line_ignored_next     = 1'b0;
        record_kind_char_next = 8'h00;
        record_length_next    = 8'h00;
        record_offset_next    = 16'h0000;
        pending_segment_next  = 16'h0000;
        high_nibble_next      = 4'h0;
      end else if (line_position < POS_LIMIT) begin
        line_position_next = line_position + POS_W'(1);
        if (line_position == POS_START) begin
          if (char_in != CHAR_COLON) begin
            line_ignored_next = 1'b1;
          end
        end else if (!line_ignored) begin
          priority if (line_position <= POS_LEN_END) begin
            record_length_next = {record_length[3:0], digit};
          end else if (line_position <= POS_OFS_END) begin
            record_offset_next = {record_offset[11:0], digit};
            if (line_position == POS_OFS_END) begin
              data_addr_next = {1'b0, segment_base, record_offset[11:0], digit};
            end
          end else if (line_position == POS_KIND) begin
            record_kind_char_next = char_in;
          end else if (line_position >= POS_BODY_START) begin
            if (record_kind_char == CHAR_FOUR) begin
              if (line_position <= POS_SEG_END) begin
                pending_segment_next = {pending_segment[11:0], digit};
              end
            end else if (record_kind_char == CHAR_ZERO) begin
              if (line_position[0]) begin
                high_nibble_next = digit;
              end else begin
                // Emit the byte if it is part of the record and in the window
                data_addr_next = data_addr + 33'd1;
                if (CMP_W'(byte_index) < CMP_W'(record_length) && in_window) begin
                  push             = 1'b1;
                  push_data.offset = data_addr[31:0] - window_low;
                  push_data.data   = {high_nibble, digit};
                end
              end
            end
          end else begin
            // Skip the first kind digit
          end
        end
      end else begin
        // Drop characters past the line buffer
      end
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      line_position    <= POS_START;
      line_ignored     <= 1'b0;
      escape_pending   <= 1'b0;
      record_kind_char <= 8'h00;
      record_length    <= 8'h00;
      record_offset    <= 16'h0000;
      segment_base     <= 16'h0000;
      pending_segment  <= 16'h0000;
      high_nibble      <= 4'h0;
      loading_finished <= 1'b0;
    end else begin
      line_position    <= line_position_next;
      line_ignored     <= line_ignored_next;
      escape_pending   <= escape_pending_next;
      record_kind_char <= record_kind_char_next;
      record_length    <= record_length_next;
      record_offset    <= record_offset_next;
      segment_base     <= segment_base_next;
      pending_segment  <= pending_segment_next;
      high_nibble      <= high_nibble_next;
      loading_finished <= loading_finished_next;
    end
  end

  // Running byte address of the current data record
  always_ff @(posedge clk) begin
    data_addr <= data_addr_next;
  end

  ihwl_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign write_offset = out_data.offset;
  assign write_data   = out_data.data;
  assign end_of_file  = out_data.eof;

  `IHWL_ASSERT(a_quiet_after_eof, clk, rst, loading_finished |-> !push, "result after end of file")
  `IHWL_ASSERT(a_eof_latches, clk, rst, (push && push_data.eof) |=> loading_finished, "end of file not latched")
  `IHWL_ASSERT(a_pos_limit, clk, rst, line_position <= POS_LIMIT, "line position past buffer limit")
  `IHWL_ASSERT_ALWAYS(a_no_push_unaccepted, clk, push |-> accept, "result without an accepted character")

endmodule

/* bench/intel_hex_window_loader_tb.sv */
// Self-checking testbench of the hex window loader: directed records, random text, pressure.
module intel_hex_window_loader_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ihwl_pkg::*;

  localparam int          RESET_CYCLES     = 6;
  localparam int          SETTLE_CYCLES    = 4;
  localparam int          DRAIN_CYCLES     = 20;
  localparam int          LONG_HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT      = 300000;
  localparam int          REPORT_CAP       = 40;

  // Record kind that is never acted on; stands in for an early end-of-file kind
  localparam logic [7:0]           CHAR_TWO   = 8'h32;
  // Register index that decodes to no register
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = '1;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           char_in = 8'h00;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [31:0]          write_offset;
  logic [7:0]           write_data;
  logic                 end_of_file;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = 32'h0;

  intel_hex_window_loader DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_in      (char_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .write_offset (write_offset),
    .write_data   (write_data),
    .end_of_file  (end_of_file),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Parser state of the predictor, at reset values
  int          line_len    = 0;
  bit          line_skip   = 1'b0;
  bit          esc_pending = 1'b0;
  logic [7:0]  kind_char   = 8'h00;
  logic [7:0]  rec_len     = 8'h00;
  logic [15:0] rec_ofs     = 16'h0000;
  logic [15:0] seg_base    = 16'h0000;
  logic [15:0] seg_pending = 16'h0000;
  logic [3:0]  hi_nib      = 4'h0;
  bit          eof_seen    = 1'b0;
  logic [31:0] win_low     = 32'h0000_0000;
  logic [31:0] win_high    = 32'hFFFF_FFFF;

  result_t     expected_writes[$];

  int          error_count    = 0;
  int unsigned items_sent     = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int          hold_req       = 0;
  int          hold_left      = 0;
  bit          eof_armed      = 1'b0;

  // Clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Abort the run at the cycle limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Drive the output stall: a requested long hold first, else random stalls
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Decode one hex digit; anything that is not a digit reads as zero
  function automatic logic [3:0] digit_of(input logic [7:0] c);
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      return c[3:0];
    end
    if ((c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) || (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)) begin
      return c[3:0] + 4'd9;
    end
    return 4'h0;
  endfunction

  // Forget everything gathered on the current line
  function automatic void clear_line();
    line_len    = 0;
    line_skip   = 1'b0;
    kind_char   = 8'h00;
    rec_len     = 8'h00;
    rec_ofs     = 16'h0000;
    seg_pending = 16'h0000;
    hi_nib      = 4'h0;
  endfunction

  // Advance the predicted parser by one accepted character
  function automatic void parse_char(input logic [7:0] c);
    int unsigned p;
    int unsigned k;
    logic [3:0]  d;
    logic [32:0] addr;
    result_t     r;
    if (eof_seen) return;
    if (esc_pending) begin
      esc_pending = 1'b0;
      return;
    end
    if (c == CHAR_BACKSLASH) begin
      esc_pending = 1'b1;
      return;
    end
    // Close the line: commit a segment or raise end of file
    if (c == CHAR_NEWLINE) begin
      if (line_len > 0 && !line_skip) begin
        if (kind_char == CHAR_FOUR) begin
          seg_base = seg_pending;
        end else if (kind_char == CHAR_ONE) begin
          eof_seen = 1'b1;
          r.offset = 32'h0;
          r.data   = 8'h00;
          r.eof    = 1'b1;
          expected_writes.push_back(r);
        end
      end
      clear_line();
      return;
    end
    // Drop characters past the line buffer
    if (line_len >= POS_LIMIT) return;
    p = line_len;
    line_len++;
    if (p == POS_START) begin
      if (c != CHAR_COLON) line_skip = 1'b1;
      return;
    end
    if (line_skip) return;
    d = digit_of(c);
    if (p <= POS_LEN_END) begin
      rec_len = {rec_len[3:0], d};
    end else if (p <= POS_OFS_END) begin
      rec_ofs = {rec_ofs[11:0], d};
    end else if (p == POS_KIND) begin
      kind_char = c;
    end else if (p >= POS_BODY_START) begin
      if (kind_char == CHAR_FOUR) begin
        if (p <= POS_SEG_END) seg_pending = {seg_pending[11:0], d};
      end else if (kind_char == CHAR_ZERO) begin
        if (p % 2 == 1) begin
          hi_nib = d;
        end else begin
          k = (p - POS_DATA_BASE) >> 1;
          if (k < rec_len) begin
            addr = {1'b0, seg_base, 16'h0000} + 33'(rec_ofs) + 33'(k);
            if (addr >= {1'b0, win_low} && addr <= {1'b0, win_high}) begin
              r.offset = addr[31:0] - win_low;
              r.data   = {hi_nib, d};
              r.eof    = 1'b0;
              expected_writes.push_back(r);
            end
          end
        end
      end
    end
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= REPORT_CAP) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  // Compare each output transaction with the oldest expectation
  always @(negedge clk) begin
    result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction offset %h data %h eof %b",
                                  write_offset, write_data, end_of_file));
      end else begin
        want = expected_writes.pop_front();
        check_field("write_offset", write_offset, want.offset);
        check_field("write_data", 32'(write_data), 32'(want.data));
        check_field("end_of_file", 32'(end_of_file), 32'(want.eof));
      end
    end
  end

  // Send one character and update the predictor when it is taken
  task automatic send_char(input logic [7:0] c);
    logic [7:0] ch;
    ch = c;
    // Keep an end-of-file record out of the text until the last test
    if (!eof_armed && !esc_pending && !line_skip && line_len == POS_KIND && ch == CHAR_ONE) begin
      ch = CHAR_TWO;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    char_in  <= ch;
    do @(negedge clk); while (in_stall !== 1'b0);
    @(posedge clk);
    items_sent++;
    parse_char(ch);
  endtask

  // Send a text; mut_pct sets how often escapes or stray bytes are mixed in
  task automatic send_text(input string text, input int unsigned mut_pct);
    int unsigned r;
    for (int i = 0; i < text.len(); i++) begin
      r = $urandom_range(99);
      if (r < mut_pct) begin
        send_char(CHAR_BACKSLASH);
        send_char(8'($urandom_range(255)));
        send_char(text[i]);
      end else if (r < 2 * mut_pct) begin
        send_char(8'($urandom_range(255)));
      end else begin
        send_char(text[i]);
      end
    end
  endtask

  // Hold the input until every expected transaction has arrived
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (cfg_ready !== 1'b1);
    @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_WINDOW_LOW) win_low = val;
    else if (idx == REG_WINDOW_HIGH) win_high = val;
  endtask

  function automatic logic [15:0] pick_offset();
    case ($urandom_range(3))
      0:       return win_low[15:0] - 16'($urandom_range(8));
      1:       return win_high[15:0] - 16'($urandom_range(16));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_segment();
    case ($urandom_range(5))
      0, 1, 2: return win_low[31:16];
      3:       return win_high[31:16];
      4:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_data_record(input int unsigned len, input int unsigned pairs,
                                  input int unsigned mut_pct);
    string text;
    text = $sformatf(":%02X%04X00", 8'(len), pick_offset());
    repeat (pairs) text = {text, $sformatf("%02X", 8'($urandom_range(255)))};
    text = {text, $sformatf("%02X\n", 8'($urandom_range(255)))};
    if ($urandom_range(1)) text = text.tolower();
    send_text(text, mut_pct);
  endtask

  // One random line: mostly well-formed records, some noise and broken ones
  task automatic send_random_line();
    int unsigned pick;
    int unsigned len;
    int unsigned ndig;
    logic [15:0] seg;
    logic [3:0]  other_kind;
    string       text;
    pick = $urandom_range(99);
    len  = ($urandom_range(49) == 0) ? $urandom_range(17, 60) : $urandom_range(0, 16);
    if (pick < 55) begin
      send_data_record(len, len, 2);
    end else if (pick < 70) begin
      seg  = pick_segment();
      ndig = ($urandom_range(7) == 0) ? $urandom_range(0, 6) : 4;
      text = ":02000004";
      for (int i = 0; i < ndig; i++) begin
        text = {text, $sformatf("%X", (i < 4) ? seg[15 - 4 * i -: 4] : 4'($urandom_range(15)))};
      end
      text = {text, $sformatf("%02X\n", 8'($urandom_range(255)))};
      if ($urandom_range(1)) text = text.tolower();
      send_text(text, 2);
    end else if (pick < 80) begin
      other_kind = 4'($urandom_range(2, 15));
      if (other_kind == 4'h4) other_kind = 4'h3;
      text = $sformatf(":%02X%04X%X%X", 8'(len), 16'($urandom), 4'($urandom_range(15)), other_kind);
      repeat (len) text = {text, $sformatf("%02X", 8'($urandom_range(255)))};
      send_text({text, "\n"}, 2);
    end else if (pick < 90) begin
      repeat ($urandom_range(1, 30)) send_char(8'($urandom_range(255)));
      send_char(CHAR_NEWLINE);
    end else begin
      send_data_record(len, $urandom_range(0, len + 4), 15);
    end
  endtask

  task automatic test_data_records();
    send_text(":0400100011223344CC\n", 0);
    // Top 16-bit offset with the smallest and largest data bytes
    send_text(":02FFFF00FF0001\n", 0);
    // Zero length: data pairs are ignored
    send_text(":00002000ABCD\n", 0);
    send_text(":03abcd00a5b6c7\n", 0);
    // Only the second kind digit selects the record kind
    send_text(":0100A01077\n", 0);
  endtask

  task automatic test_segments();
    send_text(":020000041234B4\n", 0);
    send_text(":0200100055AA\n", 0);
    // Short segment field loads its two digits right-aligned
    send_text(":0100000412\n", 0);
    send_text(":01000000EE\n", 0);
    // Top of the address space; later bytes lie past 32 bits
    send_text(":02000004FFFF\n", 0);
    send_text(":04FFFE0001020304\n", 0);
    send_text(":020000040000FA\n", 0);
  endtask

  task automatic test_special_cases();
    string text;
    // Escaped newline does not end the line
    send_text(":02000000AA\\\nBB\n", 0);
    // Escape drops the next character inside a field
    send_text(":0100\\X30000011\n", 0);
    // Escaped backslash
    send_text(":01009000\\\\77\n", 0);
    // Non-hex digits read as zero
    send_text(":01004000G5\n", 0);
    send_text(":G100500012\n", 0);
    // Lines that do not start with a colon, empty lines
    send_text("x:0100600099\n", 0);
    send_text("\n", 0);
    send_text(":\n", 0);
    // Short line and surplus data pairs
    send_text(":0400700011\n", 0);
    send_text(":01008000AABBCC\n", 0);
    // Other record kinds are ignored
    send_text(":02000002123400\n", 0);
    send_text(":0100900503\n", 0);
    // Long line: bytes past the buffer are dropped, escapes still apply there
    text = ":FF010000";
    for (int i = 0; i < 251; i++) text = {text, $sformatf("%02X", 8'(i))};
    send_text({text, "\\\n77\n"}, 0);
  endtask

  task automatic test_windows();
    write_reg(REG_WINDOW_LOW, 32'h0000_1000);
    write_reg(REG_WINDOW_HIGH, 32'h0000_100F);
    send_text(":180FFC000102030405060708090A0B0C0D0E0F101112131415161718\n", 0);
    // Empty window: low above high
    write_reg(REG_WINDOW_LOW, 32'h0000_2000);
    write_reg(REG_WINDOW_HIGH, 32'h0000_1FFF);
    send_text(":201FF000000102030405060708090A0B0C0D0E0F101112131415161718191A1B1C1D1E1F\n", 0);
    // Single-byte window at the very top
    write_reg(REG_WINDOW_LOW, 32'hFFFF_FFFF);
    write_reg(REG_WINDOW_HIGH, 32'hFFFF_FFFF);
    send_text(":02000004FFFF\n", 0);
    send_text(":04FFFE00A1A2A3A4\n", 0);
    send_text(":020000040000FA\n", 0);
    // Single-byte window at the bottom; a write to no register changes nothing
    write_reg(REG_WINDOW_LOW, 32'h0000_0000);
    write_reg(REG_WINDOW_HIGH, 32'h0000_0000);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_text(":0400000055667788\n", 0);
    write_reg(REG_WINDOW_HIGH, 32'hFFFF_FFFF);
  endtask

  task automatic test_random(input logic [31:0] lo, input logic [31:0] hi,
                             input int unsigned goal);
    int unsigned start;
    write_reg(REG_WINDOW_LOW, lo);
    write_reg(REG_WINDOW_HIGH, hi);
    start = items_sent;
    while (items_sent - start < goal) send_random_line();
    wait_idle();
  endtask

  task automatic test_backpressure();
    write_reg(REG_WINDOW_LOW, 32'h0000_0000);
    write_reg(REG_WINDOW_HIGH, 32'hFFFF_FFFF);
    send_text(":020000040000FA\n", 0);
    // Hold the output off while records keep coming, so the input stalls
    hold_req = LONG_HOLD_CYCLES;
    repeat (2) send_data_record(16, 16, 0);
    // Pause until every result is out, then resume
    wait_idle();
    send_data_record(8, 8, 0);
    wait_idle();
  endtask

  task automatic test_end_of_file();
    eof_armed = 1'b1;
    send_text(":00000001FF\n", 0);
    // Everything after end of file is ignored
    send_text(":0400000011223344CC\n", 0);
    send_text(":020000041234B4\n", 0);
    repeat (20) send_char(8'($urandom_range(255)));
    send_text(":00000001FF\n", 0);
    wait_idle();
  endtask

  initial begin
    logic [31:0] lo;
    logic [32:0] lim;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct  = 13;
    recv_stall_pct = 81;
    test_data_records();
    test_segments();
    test_special_cases();
    test_random(32'h0000_0000, 32'hFFFF_FFFF, 60);

    send_idle_pct  = 81;
    recv_stall_pct = 13;
    test_windows();
    lo = 32'h0002_8000 | 32'($urandom_range(255));
    test_random(lo, lo + 32'h0000_0FFF, 60);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    lo  = $urandom;
    lim = {1'b0, lo} + 33'($urandom_range(0, 32'h0001_0000));
    test_random(lo, lim[32] ? 32'hFFFF_FFFF : lim[31:0], 60);
    test_backpressure();
    test_end_of_file();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* intel_hex_window_loader.f */
+incdir+rtl
rtl/ihwl_pkg.sv
rtl/ihwl_out_buf.sv
rtl/intel_hex_window_loader.sv
bench/intel_hex_window_loader_tb.sv
